// ----- rtl/spk_pkg.sv -----
`default_nettype none

package spk_pkg;

  // Fixed widths of the channel fields
  localparam int FIELD_W   = 12;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 3;
  localparam int IDX_OUT_W = 9;
  localparam int CNT_OUT_W = 10;
  localparam int CFG_IDX_W = 1;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ENTRIES = 512;
  localparam int DEF_GAP_PIXELS  = 3;
  localparam int DEF_COORD_BITS  = 12;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_START = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PLACE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PLACED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_SKIPPED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_PAGE_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STAT_W-1:0] ST_HIT        = 3'd4;
  localparam logic [STAT_W-1:0] ST_MISS       = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_H = 1'b1;

  // Query token passed down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [FIELD_W-1:0]   pt_x;
    logic [FIELD_W-1:0]   pt_y;
    logic [FIELD_W-1:0]   hit_x;
    logic [FIELD_W-1:0]   hit_y;
    logic [IDX_OUT_W-1:0] hit_idx;
  } tok_t;

endpackage

`default_nettype wire

// ----- rtl/spk_in_if.sv -----
`default_nettype none

interface spk_in_if;
  import spk_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [FIELD_W-1:0] rect_width;
  logic [FIELD_W-1:0] rect_height;
  logic [FIELD_W-1:0] point_x;
  logic [FIELD_W-1:0] point_y;

  modport source (
    output valid, action, rect_width, rect_height, point_x, point_y,
    input  ready
  );

  modport sink (
    input  valid, action, rect_width, rect_height, point_x, point_y,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/spk_out_if.sv -----
`default_nettype none

interface spk_out_if;
  import spk_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [FIELD_W-1:0]   pos_x;
  logic [FIELD_W-1:0]   pos_y;
  logic [IDX_OUT_W-1:0] entry_index;
  logic [CNT_OUT_W-1:0] placed_count;

  modport source (
    output valid, status, pos_x, pos_y, entry_index, placed_count,
    input  ready
  );

  modport sink (
    input  valid, status, pos_x, pos_y, entry_index, placed_count,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/spk_cell.sv -----
`default_nettype none

module spk_cell
  import spk_pkg::*;
#(
  parameter int CELL_IDX   = 0,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int IDX_W      = 9,
  parameter int CNT_W      = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tok_t                  tok_i,
  output tok_t                       tok_o,
  input  wire logic                  wr_en,
  input  wire logic [IDX_W-1:0]      wr_idx,
  input  wire logic [COORD_BITS-1:0] wr_x,
  input  wire logic [COORD_BITS-1:0] wr_y,
  input  wire logic [COORD_BITS-1:0] wr_w,
  input  wire logic [COORD_BITS-1:0] wr_h,
  input  wire logic [CNT_W-1:0]      count
);

  localparam int CMP_W = ((COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W) + 1;

  logic [COORD_BITS-1:0] x_r, y_r, w_r, h_r;
  tok_t                  tok_r, tok_nxt;
  logic                  live;
  logic                  inside_pt;
  logic [CMP_W-1:0]      px_e, py_e, x_e, y_e, xr_e, yb_e;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
      x_r <= wr_x;
      y_r <= wr_y;
      w_r <= wr_w;
      h_r <= wr_h;
    end
  end

  // entry only counts while it lies below the fill level of the page
  assign live = CNT_W'(CELL_IDX) < count;

  always_comb begin
    px_e = CMP_W'(tok_i.pt_x);
    py_e = CMP_W'(tok_i.pt_y);
    x_e  = CMP_W'(x_r);
    y_e  = CMP_W'(y_r);
    xr_e = x_e + CMP_W'(w_r);
    yb_e = y_e + CMP_W'(h_r);
    // strict containment, edges excluded
    inside_pt = (py_e > y_e) && (px_e > x_e) && (py_e < yb_e) && (px_e < xr_e);

    tok_nxt = tok_i;
    if (tok_i.valid && !tok_i.hit && live && inside_pt) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_x   = FIELD_W'(x_r);
      tok_nxt.hit_y   = FIELD_W'(y_r);
      tok_nxt.hit_idx = IDX_OUT_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// ----- rtl/spk_ctrl.sv -----
`default_nettype none

module spk_ctrl
  import spk_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int GAP_PIXELS  = DEF_GAP_PIXELS,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int IDX_W       = 9,
  parameter int CNT_W       = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  spk_in_if.sink                     in_chan,
  spk_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [FIELD_W-1:0]    cfg_wdata,
  output tok_t                       head_tok,
  input  wire tok_t                  tail_tok,
  output logic                       wr_en,
  output logic [IDX_W-1:0]           wr_idx,
  output logic [COORD_BITS-1:0]      wr_x,
  output logic [COORD_BITS-1:0]      wr_y,
  output logic [COORD_BITS-1:0]      wr_w,
  output logic [COORD_BITS-1:0]      wr_h,
  output logic [CNT_W-1:0]           count
);

  localparam int CX_W = 13;
  localparam int CY_W = 14;
  localparam int GAP2 = 2 * GAP_PIXELS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PLACE = 2'd1;
  localparam logic [1:0] S_QUERY = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [FIELD_W-1:0]   win_w_r, win_w_nxt, win_h_r, win_h_nxt;
  logic [CX_W-1:0]      cur_x_r, cur_x_nxt;
  logic [CY_W-1:0]      cur_y_r, cur_y_nxt;
  logic [FIELD_W-1:0]   row_h_r, row_h_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 full_r, full_nxt;
  logic [FIELD_W-1:0]   pw_r, pw_nxt, ph_r, ph_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [FIELD_W-1:0]   pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [IDX_OUT_W-1:0] idx_r, idx_nxt;
  logic [CNT_OUT_W-1:0] pcnt_r, pcnt_nxt;

  logic                 fire;
  logic                 res_ld;
  logic [CY_W:0]        y_bottom;
  logic [CY_W-1:0]      x_right;

  assign in_chan.ready = (state_r == S_IDLE) && !out_valid_r;
  assign fire          = in_chan.valid && in_chan.ready;

  // right edge test of the incoming rectangle, and bottom edge of the pending one
  assign x_right  = CY_W'(in_chan.rect_width) + CY_W'(cur_x_r) + CY_W'(GAP2);
  assign y_bottom = (CY_W+1)'(cur_y_r) + (CY_W+1)'(ph_r) + (CY_W+1)'(GAP_PIXELS);

  always_comb begin
    state_nxt  = state_r;
    win_w_nxt  = win_w_r;
    win_h_nxt  = win_h_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    row_h_nxt  = row_h_r;
    count_nxt  = count_r;
    full_nxt   = full_r;
    pw_nxt     = pw_r;
    ph_nxt     = ph_r;
    res_ld     = 1'b0;
    status_nxt = status_r;
    pos_x_nxt  = '0;
    pos_y_nxt  = '0;
    idx_nxt    = '0;
    wr_en      = 1'b0;

    head_tok       = '0;
    head_tok.valid = fire && (in_chan.action == ACT_QUERY);
    head_tok.pt_x  = in_chan.point_x;
    head_tok.pt_y  = in_chan.point_y;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_WIN_W: win_w_nxt = cfg_wdata;
        CFG_WIN_H: win_h_nxt = cfg_wdata;
        default:   ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (fire) begin
          case (in_chan.action)
            ACT_START: begin
              cur_x_nxt  = CX_W'(GAP_PIXELS);
              cur_y_nxt  = CY_W'(GAP_PIXELS);
              row_h_nxt  = '0;
              count_nxt  = '0;
              full_nxt   = 1'b0;
              res_ld     = 1'b1;
              status_nxt = ST_CLEARED;
            end
            ACT_PLACE: begin
              if (full_r) begin
                res_ld     = 1'b1;
                status_nxt = ST_PAGE_FULL;
              end else if ((in_chan.rect_width == '0) || (in_chan.rect_height == '0)) begin
                res_ld     = 1'b1;
                status_nxt = ST_SKIPPED;
              end else if (count_r >= CNT_W'(MAX_ENTRIES)) begin
                res_ld     = 1'b1;
                status_nxt = ST_TABLE_FULL;
              end else begin
                // wrap to a new shelf; kept even if the height test then fails
                if (x_right > CY_W'(win_w_r)) begin
                  cur_x_nxt = CX_W'(GAP_PIXELS);
                  cur_y_nxt = cur_y_r + CY_W'(row_h_r) + CY_W'(GAP_PIXELS);
                  row_h_nxt = '0;
                end
                pw_nxt    = in_chan.rect_width;
                ph_nxt    = in_chan.rect_height;
                state_nxt = S_PLACE;
              end
            end
            ACT_QUERY: state_nxt = S_QUERY;
            default: begin
              res_ld     = 1'b1;
              status_nxt = ST_MISS;
            end
          endcase
        end
      end
      S_PLACE: begin
        res_ld    = 1'b1;
        state_nxt = S_IDLE;
        if (y_bottom > (CY_W+1)'(win_h_r)) begin
          full_nxt   = 1'b1;
          status_nxt = ST_PAGE_FULL;
        end else begin
          wr_en      = 1'b1;
          count_nxt  = count_r + 1'b1;
          cur_x_nxt  = cur_x_r + CX_W'(pw_r) + CX_W'(GAP_PIXELS);
          row_h_nxt  = (ph_r > row_h_r) ? ph_r : row_h_r;
          status_nxt = ST_PLACED;
          pos_x_nxt  = FIELD_W'(COORD_BITS'(cur_x_r));
          pos_y_nxt  = FIELD_W'(COORD_BITS'(cur_y_r));
          idx_nxt    = IDX_OUT_W'(count_r);
        end
      end
      S_QUERY: begin
        if (tail_tok.valid) begin
          res_ld    = 1'b1;
          state_nxt = S_IDLE;
          if (tail_tok.hit) begin
            status_nxt = ST_HIT;
            pos_x_nxt  = tail_tok.hit_x;
            pos_y_nxt  = tail_tok.hit_y;
            idx_nxt    = tail_tok.hit_idx;
          end else begin
            status_nxt = ST_MISS;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    pcnt_nxt = CNT_OUT_W'(count_nxt);
    if (res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_w_r     <= FIELD_W'(640);
      win_h_r     <= FIELD_W'(480);
      cur_x_r     <= CX_W'(GAP_PIXELS);
      cur_y_r     <= CY_W'(GAP_PIXELS);
      row_h_r     <= '0;
      count_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_w_r     <= win_w_nxt;
      win_h_r     <= win_h_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      row_h_r     <= row_h_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pw_r <= pw_nxt;
    ph_r <= ph_nxt;
    if (res_ld) begin
      status_r <= status_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      idx_r    <= idx_nxt;
      pcnt_r   <= pcnt_nxt;
    end
  end

  assign wr_idx = IDX_W'(count_r);
  assign wr_x   = COORD_BITS'(cur_x_r);
  assign wr_y   = COORD_BITS'(cur_y_r);
  assign wr_w   = COORD_BITS'(pw_r);
  assign wr_h   = COORD_BITS'(ph_r);
  assign count  = count_r;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = status_r;
  assign out_chan.pos_x        = pos_x_r;
  assign out_chan.pos_y        = pos_y_r;
  assign out_chan.entry_index  = idx_r;
  assign out_chan.placed_count = pcnt_r;

endmodule

`default_nettype wire

// ----- rtl/shelf_packer_with_hit_test_unit.sv -----
// Start page, skipped, refused and unused actions load the result register
// straight from the transfer; a place first passes the place state, and a query
// first sends its token through every cell of the entry chain. One item at a
// time: the next transfer is taken the cycle after the result has left, so a
// result stall holds off the next item.
// Reset: window 640x480, empty page, cursor at the gap; cell contents are not
// cleared and are never looked at until written on the current page.
`default_nettype none

module shelf_packer_with_hit_test_unit
  import spk_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int GAP_PIXELS  = DEF_GAP_PIXELS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  spk_in_if.sink                    in_chan,
  spk_out_if.source                 out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [FIELD_W-1:0]   cfg_wdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  tok_t                  tok [MAX_ENTRIES+1];
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [COORD_BITS-1:0] wr_x, wr_y, wr_w, wr_h;
  logic [CNT_W-1:0]      count;

  spk_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .GAP_PIXELS  (GAP_PIXELS),
    .COORD_BITS  (COORD_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .head_tok  (tok[0]),
    .tail_tok  (tok[MAX_ENTRIES]),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_x      (wr_x),
    .wr_y      (wr_y),
    .wr_w      (wr_w),
    .wr_h      (wr_h),
    .count     (count)
  );

  // one cell per table entry; the query token moves one cell each cycle
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    spk_cell #(
      .CELL_IDX   (g),
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1]),
      .wr_en  (wr_en),
      .wr_idx (wr_idx),
      .wr_x   (wr_x),
      .wr_y   (wr_y),
      .wr_w   (wr_w),
      .wr_h   (wr_h),
      .count  (count)
    );
  end

endmodule

`default_nettype wire

// ----- rtl/spk_checker.sv -----
`default_nettype none

module spk_checker
  import spk_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [STAT_W-1:0]    status,
  input wire logic [FIELD_W-1:0]   pos_x,
  input wire logic [FIELD_W-1:0]   pos_y,
  input wire logic [IDX_OUT_W-1:0] entry_index,
  input wire logic [CNT_OUT_W-1:0] placed_count
);

  // a waiting result is held until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(placed_count))
    else $error("result dropped or changed while stalled");

  // one item in flight: no new transfer while a result waits
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  // a placed rectangle is the last one counted on the page
  a_place_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_PLACED) |->
      (placed_count != '0) && (entry_index == IDX_OUT_W'(placed_count - 1'b1)))
    else $error("placed index does not match count");

  // results without a rectangle carry zero position and index
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_SKIPPED || status == ST_PAGE_FULL ||
                  status == ST_TABLE_FULL || status == ST_MISS ||
                  status == ST_CLEARED)
      |-> (pos_x == '0) && (pos_y == '0) && (entry_index == '0))
    else $error("non-zero position on an empty result");

endmodule

bind shelf_packer_with_hit_test_unit spk_checker u_spk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .status       (out_chan.status),
  .pos_x        (out_chan.pos_x),
  .pos_y        (out_chan.pos_y),
  .entry_index  (out_chan.entry_index),
  .placed_count (out_chan.placed_count)
);

`default_nettype wire

// ----- tb/shelf_packer_with_hit_test_unit_tb.sv -----
`default_nettype none

module shelf_packer_with_hit_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spk_pkg::*;

  localparam int SLOTS      = DEF_MAX_ENTRIES;
  localparam int GAP        = DEF_GAP_PIXELS;
  localparam int TOTAL_JOBS = 1150;
  localparam int TABLE_AT   = 400;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [FIELD_W-1:0] rect_width;
    logic [FIELD_W-1:0] rect_height;
    logic [FIELD_W-1:0] point_x;
    logic [FIELD_W-1:0] point_y;
  } job_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [FIELD_W-1:0]   pos_x;
    logic [FIELD_W-1:0]   pos_y;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [CNT_OUT_W-1:0] placed_count;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [FIELD_W-1:0]   cfg_wdata;

  spk_in_if  in_ch ();
  spk_out_if out_ch ();

  shelf_packer_with_hit_test_unit #(
    .MAX_ENTRIES(DEF_MAX_ENTRIES),
    .GAP_PIXELS (DEF_GAP_PIXELS),
    .COORD_BITS (DEF_COORD_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the packer state
  logic [FIELD_W-1:0] win_w = 12'd640;
  logic [FIELD_W-1:0] win_h = 12'd480;
  logic [12:0]        cur_x;
  logic [13:0]        cur_y;
  logic [11:0]        shelf_h;
  logic [9:0]         n_placed;
  logic               full_page;
  logic [FIELD_W-1:0] tab_x [SLOTS];
  logic [FIELD_W-1:0] tab_y [SLOTS];
  logic [FIELD_W-1:0] tab_w [SLOTS];
  logic [FIELD_W-1:0] tab_h [SLOTS];

  job_t   jobs [$];
  reply_t replies_due [$];
  job_t   drv_job;
  job_t   mon_job;
  reply_t seen;
  reply_t want;
  int     send_idle = 18;
  int     recv_idle = 88;
  int     issued;
  int     faults;
  int     reply_no;

  function automatic void open_page();
    cur_x     = 13'(GAP);
    cur_y     = 14'(GAP);
    shelf_h   = '0;
    n_placed  = '0;
    full_page = 1'b0;
  endfunction

  function automatic reply_t layout_step(input job_t j);
    reply_t      r;
    int unsigned w, h, px, py;
    int          i;
    bit          found;
    r  = '0;
    w  = j.rect_width;
    h  = j.rect_height;
    px = j.point_x;
    py = j.point_y;
    case (j.action)
      ACT_START: begin
        open_page();
        r.status = ST_CLEARED;
      end
      ACT_PLACE: begin
        if (full_page) begin
          r.status = ST_PAGE_FULL;
        end else if (w == 0 || h == 0) begin
          r.status = ST_SKIPPED;
        end else if (n_placed >= SLOTS) begin
          r.status = ST_TABLE_FULL;
        end else begin
          // wrap to a fresh shelf when the right margin would be crossed
          if (w + cur_x + 2 * GAP > win_w) begin
            cur_x   = 13'(GAP);
            cur_y   = 14'(cur_y + shelf_h + GAP);
            shelf_h = '0;
          end
          if (cur_y + h + GAP > win_h) begin
            full_page = 1'b1;
            r.status  = ST_PAGE_FULL;
          end else begin
            tab_x[n_placed] = cur_x[FIELD_W-1:0];
            tab_y[n_placed] = cur_y[FIELD_W-1:0];
            tab_w[n_placed] = FIELD_W'(w);
            tab_h[n_placed] = FIELD_W'(h);
            r.status      = ST_PLACED;
            r.pos_x       = cur_x[FIELD_W-1:0];
            r.pos_y       = cur_y[FIELD_W-1:0];
            r.entry_index = n_placed[IDX_OUT_W-1:0];
            n_placed      = n_placed + 1'b1;
            cur_x         = 13'(cur_x + w + GAP);
            if (h > shelf_h) shelf_h = FIELD_W'(h);
          end
        end
      end
      ACT_QUERY: begin
        r.status = ST_MISS;
        found    = 1'b0;
        // first entry with the point strictly inside wins
        for (i = 0; i < n_placed && !found; i++) begin
          if (py > tab_y[i] && px > tab_x[i] &&
              py < tab_y[i] + tab_h[i] && px < tab_x[i] + tab_w[i]) begin
            found         = 1'b1;
            r.status      = ST_HIT;
            r.pos_x       = tab_x[i];
            r.pos_y       = tab_y[i];
            r.entry_index = IDX_OUT_W'(i);
          end
        end
      end
      default: r.status = ST_MISS;
    endcase
    r.placed_count = n_placed;
    return r;
  endfunction

  task automatic report_fault(input string msg);
    faults++;
    if (faults <= 100) $display("[%0t] reply %0d: %s", $time, reply_no, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_fault($sformatf("%s is %0d, should be %0d", name, got, exp_val));
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (jobs.size() != 0 && $urandom_range(99) >= send_idle) begin
        drv_job           = jobs.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.action      <= drv_job.action;
        in_ch.rect_width  <= drv_job.rect_width;
        in_ch.rect_height <= drv_job.rect_height;
        in_ch.point_x     <= drv_job.point_x;
        in_ch.point_y     <= drv_job.point_y;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);

  // transfer monitor and scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        mon_job.action      = in_ch.action;
        mon_job.rect_width  = in_ch.rect_width;
        mon_job.rect_height = in_ch.rect_height;
        mon_job.point_x     = in_ch.point_x;
        mon_job.point_y     = in_ch.point_y;
        replies_due.push_back(layout_step(mon_job));
      end
      if (out_ch.valid && out_ch.ready) begin
        reply_no++;
        seen.status       = out_ch.status;
        seen.pos_x        = out_ch.pos_x;
        seen.pos_y        = out_ch.pos_y;
        seen.entry_index  = out_ch.entry_index;
        seen.placed_count = out_ch.placed_count;
        if (replies_due.size() == 0) begin
          report_fault($sformatf("unexpected result, status %0d", seen.status));
        end else begin
          want = replies_due.pop_front();
          check_field("status", seen.status, want.status);
          check_field("pos_x", seen.pos_x, want.pos_x);
          check_field("pos_y", seen.pos_y, want.pos_y);
          check_field("entry_index", seen.entry_index, want.entry_index);
          check_field("placed_count", seen.placed_count, want.placed_count);
        end
      end
    end
  end

  function automatic int rnd12();
    return $urandom_range(4095);
  endfunction

  function automatic job_t mk(input logic [ACT_W-1:0] a, input int w, input int h,
                              input int px, input int py);
    job_t j;
    j.action      = a;
    j.rect_width  = FIELD_W'(w);
    j.rect_height = FIELD_W'(h);
    j.point_x     = FIELD_W'(px);
    j.point_y     = FIELD_W'(py);
    return j;
  endfunction

  function automatic void feed(input job_t j);
    jobs.push_back(j);
    issued++;
  endfunction

  function automatic job_t rand_place();
    int sel, mw, mh;
    sel = $urandom_range(15);
    mw  = (win_w > 12) ? win_w / 4 : 3;
    mh  = (win_h > 15) ? win_h / 5 : 3;
    if (sel == 0) return mk(ACT_PLACE, 0, rnd12(), rnd12(), rnd12());
    if (sel == 1) return mk(ACT_PLACE, rnd12(), 0, rnd12(), rnd12());
    if (sel == 2) return mk(ACT_PLACE, rnd12(), rnd12(), rnd12(), rnd12());
    return mk(ACT_PLACE, $urandom_range(mw, 1), $urandom_range(mh, 1), rnd12(), rnd12());
  endfunction

  // point near a stored rectangle: mostly inside, sometimes on its border; otherwise random
  function automatic job_t aim_query();
    int i, x, y, w, h, px, py;
    if (n_placed == 0 || $urandom_range(7) == 0)
      return mk(ACT_QUERY, rnd12(), rnd12(), rnd12(), rnd12());
    i  = $urandom_range(n_placed - 1);
    x  = tab_x[i];
    y  = tab_y[i];
    w  = tab_w[i];
    h  = tab_h[i];
    px = (w > 1) ? $urandom_range(x + w - 1, x + 1) : x;
    py = (h > 1) ? $urandom_range(y + h - 1, y + 1) : y;
    case ($urandom_range(9))
      0: px = x;
      1: px = x + w;
      2: py = y;
      3: py = y + h;
      4: begin
        px = x + 1;
        py = y + 1;
      end
      default: ;
    endcase
    return mk(ACT_QUERY, rnd12(), rnd12(), px, py);
  endfunction

  function automatic job_t noise();
    case ($urandom_range(2))
      0: return mk(ACT_SPARE, rnd12(), rnd12(), rnd12(), rnd12());
      1: return mk(ACT_QUERY, rnd12(), rnd12(), rnd12(), rnd12());
      default: return mk(ACT_START, rnd12(), rnd12(), rnd12(), rnd12());
    endcase
  endfunction

  task automatic drain();
    @(negedge clk);
    while (jobs.size() != 0 || in_ch.valid || replies_due.size() != 0) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_window(input int ww, input int wh);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_WIN_W;
    cfg_wdata <= FIELD_W'(ww);
    @(posedge clk);
    cfg_idx   <= CFG_WIN_H;
    cfg_wdata <= FIELD_W'(wh);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_w = FIELD_W'(ww);
    win_h = FIELD_W'(wh);
    @(negedge clk);
  endtask

  task automatic run_session();
    int n, k, d, ww, wh;
    if ($urandom_range(2) == 0) begin
      d = $urandom_range(9);
      if (d == 0) begin
        ww = $urandom_range(20);
        wh = $urandom_range(20);
      end else if (d == 1) begin
        ww = 4095;
        wh = rnd12();
      end else if (d == 2) begin
        ww = rnd12();
        wh = 4095;
      end else begin
        ww = $urandom_range(1500, 60);
        wh = $urandom_range(1200, 40);
      end
      drain();
      write_window(ww, wh);
    end
    if ($urandom_range(7) != 0) feed(mk(ACT_START, rnd12(), rnd12(), rnd12(), rnd12()));
    n = $urandom_range(24, 6);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(11) == 0) feed(noise());
      else feed(rand_place());
    end
    // hold the sender until the page is settled, then aim at what was placed
    drain();
    n = $urandom_range(8, 3);
    for (k = 0; k < n; k++) begin
      feed(aim_query());
      if ($urandom_range(5) == 0) feed(rand_place());
    end
  endtask

  // fill the table to capacity on one large page
  task automatic run_table_fill();
    int k;
    drain();
    write_window(4095, 4095);
    feed(mk(ACT_START, 0, 0, 0, 0));
    for (k = 0; k < SLOTS + 6; k++)
      feed(mk(ACT_PLACE, $urandom_range(3, 1), $urandom_range(3, 1), rnd12(), rnd12()));
    feed(mk(ACT_PLACE, 0, 2, 0, 0));
    feed(mk(ACT_PLACE, 5, 5, 0, 0));
    drain();
    for (k = 0; k < 8; k++) feed(aim_query());
    feed(mk(ACT_PLACE, 4095, 4095, 0, 0));
    feed(mk(ACT_PLACE, 1, 1, 0, 0));
  endtask

  initial begin
    bit table_done;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_WIN_W;
    cfg_wdata         = '0;
    table_done        = 1'b0;
    open_page();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: default 640x480 window, then 0x0 and 4095x4095 windows
    feed(mk(ACT_QUERY, 0, 0, 4, 4));
    feed(mk(ACT_PLACE, 0, 5, 0, 0));
    feed(mk(ACT_PLACE, 5, 0, 0, 0));
    feed(mk(ACT_PLACE, 100, 50, 0, 0));
    feed(mk(ACT_QUERY, 0, 0, 4, 4));
    feed(mk(ACT_QUERY, 0, 0, 3, 3));
    feed(mk(ACT_QUERY, 0, 0, 103, 20));
    feed(mk(ACT_QUERY, 0, 0, 102, 52));
    feed(mk(ACT_PLACE, 530, 20, 0, 0));
    feed(mk(ACT_PLACE, 4095, 10, 0, 0));
    feed(mk(ACT_PLACE, 10, 4095, 0, 0));
    feed(mk(ACT_PLACE, 1, 1, 0, 0));
    feed(mk(ACT_PLACE, 0, 0, 0, 0));
    feed(mk(ACT_SPARE, 4095, 4095, 4095, 4095));
    feed(mk(ACT_QUERY, 4095, 4095, 4095, 4095));
    feed(mk(ACT_QUERY, 0, 0, 0, 0));
    feed(mk(ACT_START, 4095, 4095, 4095, 4095));
    feed(mk(ACT_QUERY, 0, 0, 4, 4));
    drain();
    write_window(0, 0);
    feed(mk(ACT_START, 0, 0, 0, 0));
    feed(mk(ACT_PLACE, 1, 1, 0, 0));
    drain();
    write_window(4095, 4095);
    feed(mk(ACT_START, 0, 0, 0, 0));
    feed(mk(ACT_PLACE, 4095, 4095, 0, 0));
    feed(mk(ACT_START, 0, 0, 0, 0));
    feed(mk(ACT_PLACE, 4086, 4089, 0, 0));
    feed(mk(ACT_QUERY, 0, 0, 4088, 4091));

    while (issued < TOTAL_JOBS) begin
      if (issued < TOTAL_JOBS / 3) begin
        send_idle = 18;
        recv_idle = 88;
      end else if (issued < 2 * TOTAL_JOBS / 3) begin
        send_idle = 88;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (!table_done && issued >= TABLE_AT) begin
        run_table_fill();
        table_done = 1'b1;
      end else begin
        run_session();
      end
    end

    drain();
    repeat (SLOTS + 16) @(negedge clk);
    if (faults == 0) begin
      $display("shelf_packer_with_hit_test_unit verification clean");
    end else begin
      $display("shelf_packer_with_hit_test_unit verification failed");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("shelf_packer_with_hit_test_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/spk_pkg.sv
rtl/spk_in_if.sv
rtl/spk_out_if.sv
rtl/spk_cell.sv
rtl/spk_ctrl.sv
rtl/shelf_packer_with_hit_test_unit.sv
rtl/spk_checker.sv
tb/shelf_packer_with_hit_test_unit_tb.sv
